/* rtl/fct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

  // six planes, one per cell
  localparam int PLANE_COUNT = 6;
  // packing of one plane register
  localparam int PLANE_W     = 64;
  localparam int FIELD_W     = 16;
  localparam int AXES        = 3;
  localparam int DIST_SLOT   = 3;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [1:0] {
    MODE_POINT  = 2'd0,
    MODE_SPHERE = 2'd1,
    MODE_BOX    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // control that travels with an item down the row
  typedef struct packed {
    logic  valid;
    mode_e mode;
    logic  pass_all;
  } ctrl_t;

endpackage

`default_nettype wire

/* rtl/frustum_cull_test.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                   payload
// in        input      in_valid_i / in_ready_o     mode, first xyz, box max xyz, radius
// out       output     out_valid_o / out_ready_i   inside_res
// cfg       input      cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while the output side takes results; each item passes through
// two stages in each of the six plane cells, then the output register
// each cell runs three multiplies in its first stage, a sum and compare in its second
// reset clears plane registers and all valid bits; no clearing pass
// a stall on the output side fills bubbles first, input stalls only when the row is full

module frustum_cull_test #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      mode_i,
  input  logic signed [COORD_WIDTH-1:0]   first_x_i,
  input  logic signed [COORD_WIDTH-1:0]   first_y_i,
  input  logic signed [COORD_WIDTH-1:0]   first_z_i,
  input  logic signed [COORD_WIDTH-1:0]   box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0]   box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0]   box_max_z_i,
  input  logic [COORD_WIDTH-2:0]          sphere_radius_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            inside_res_o,
  input  logic                            cfg_we_i,
  input  logic [fct_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fct_pkg::PLANE_W-1:0]     cfg_data_i
);
  import fct_pkg::*;

  // links between cells; link 0 is the input, the last link feeds the output register
  ctrl_t                         ctrl_c  [PLANE_COUNT+1];
  logic                          ready_c [PLANE_COUNT+1];
  logic signed [COORD_WIDTH-1:0] first_c [PLANE_COUNT+1][AXES];
  logic signed [COORD_WIDTH-1:0] max_c   [PLANE_COUNT+1][AXES];
  logic [COORD_WIDTH-2:0]        rad_c   [PLANE_COUNT+1];

  logic out_valid_q;
  logic inside_q;

  // an unused mode starts out failed and stays so
  always_comb begin
    ctrl_c[0].valid    = in_valid_i;
    ctrl_c[0].mode     = mode_e'(mode_i);
    ctrl_c[0].pass_all = (mode_e'(mode_i) != MODE_NONE);
    first_c[0][0]      = first_x_i;
    first_c[0][1]      = first_y_i;
    first_c[0][2]      = first_z_i;
    max_c[0][0]        = box_max_x_i;
    max_c[0][1]        = box_max_y_i;
    max_c[0][2]        = box_max_z_i;
    rad_c[0]           = sphere_radius_i;
  end

  assign in_ready_o = ready_c[0];

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    logic plane_we;

    // index beyond the last plane matches no cell and is dropped
    assign plane_we = cfg_we_i && (cfg_idx_i == CFG_IDX_W'(g));

    fct_cell #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .plane_we_i (plane_we),
      .plane_i    (cfg_data_i),
      .ctrl_i     (ctrl_c[g]),
      .first_i    (first_c[g]),
      .max_i      (max_c[g]),
      .radius_i   (rad_c[g]),
      .ready_o    (ready_c[g]),
      .ctrl_o     (ctrl_c[g+1]),
      .first_o    (first_c[g+1]),
      .max_o      (max_c[g+1]),
      .radius_o   (rad_c[g+1]),
      .ready_i    (ready_c[g+1])
    );
  end

  // output register takes a new result whenever it is empty or being drained
  assign ready_c[PLANE_COUNT] = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_c[PLANE_COUNT]) begin
      out_valid_q <= ctrl_c[PLANE_COUNT].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c[PLANE_COUNT]) begin
      inside_q <= ctrl_c[PLANE_COUNT].pass_all;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

`ifndef SYNTH
  // the row only pushes back when the output side holds a result
  a_stall_from_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i))
    else $error("input stalled without output backpressure");

  // a result leaving the last cell lands in the output register
  a_last_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_c[PLANE_COUNT].valid && ready_c[PLANE_COUNT]) |=> out_valid_q)
    else $error("result from last cell lost");

  // an unused mode never comes out of the row as inside
  a_none_fails : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_c[PLANE_COUNT].valid && ctrl_c[PLANE_COUNT].mode == MODE_NONE)
      |-> !ctrl_c[PLANE_COUNT].pass_all)
    else $error("unused mode reported inside");
`endif

endmodule

`default_nettype wire

/* rtl/fct_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module fct_cell #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          plane_we_i,
  input  logic [fct_pkg::PLANE_W-1:0]   plane_i,
  input  fct_pkg::ctrl_t                ctrl_i,
  input  logic signed [COORD_WIDTH-1:0] first_i [fct_pkg::AXES],
  input  logic signed [COORD_WIDTH-1:0] max_i [fct_pkg::AXES],
  input  logic [COORD_WIDTH-2:0]        radius_i,
  output logic                          ready_o,
  output fct_pkg::ctrl_t                ctrl_o,
  output logic signed [COORD_WIDTH-1:0] first_o [fct_pkg::AXES],
  output logic signed [COORD_WIDTH-1:0] max_o [fct_pkg::AXES],
  output logic [COORD_WIDTH-2:0]        radius_o,
  input  logic                          ready_i
);
  import fct_pkg::*;

  // product width and a sum width that holds every term
  localparam int PW  = FIELD_W + COORD_WIDTH;
  localparam int SA  = PW + 2;
  localparam int SB  = FIELD_W + NORMAL_FRAC_BITS + 1;
  localparam int SC  = COORD_WIDTH + NORMAL_FRAC_BITS + 1;
  localparam int SAB = (SA > SB) ? SA : SB;
  localparam int SW  = ((SAB > SC) ? SAB : SC) + 1;

  logic [PLANE_W-1:0]           plane_q;
  logic signed [FIELD_W-1:0]    n [AXES];
  logic signed [FIELD_W-1:0]    plane_d;

  // stage a: corner select and products
  ctrl_t                        a_ctrl_q;
  logic signed [COORD_WIDTH-1:0] a_first_q [AXES];
  logic signed [COORD_WIDTH-1:0] a_max_q [AXES];
  logic [COORD_WIDTH-2:0]       a_rad_q;
  logic signed [PW-1:0]         a_prod_q [AXES];
  logic signed [PW-1:0]         a_prod_d [AXES];

  // stage b: sum, compare, hand on
  ctrl_t                        b_ctrl_q;
  ctrl_t                        b_ctrl_d;
  logic signed [COORD_WIDTH-1:0] b_first_q [AXES];
  logic signed [COORD_WIDTH-1:0] b_max_q [AXES];
  logic [COORD_WIDTH-2:0]       b_rad_q;

  logic signed [SW-1:0]         sum;
  logic signed [SW-1:0]         lim;
  logic                         pass;
  logic                         adv_a;
  logic                         adv_b;

  assign adv_b   = !b_ctrl_q.valid || ready_i;
  assign adv_a   = !a_ctrl_q.valid || adv_b;
  assign ready_o = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (plane_we_i) begin
      plane_q <= plane_i;
    end
  end

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      n[k] = plane_q[k*FIELD_W +: FIELD_W];
    end
    plane_d = plane_q[DIST_SLOT*FIELD_W +: FIELD_W];
  end

  // box mode takes the max coordinate where the normal is not negative
  always_comb begin
    logic signed [COORD_WIDTH-1:0] corner;
    for (int k = 0; k < AXES; k++) begin
      corner      = (ctrl_i.mode == MODE_BOX && !n[k][FIELD_W-1]) ? max_i[k] : first_i[k];
      a_prod_d[k] = PW'(n[k]) * PW'(corner);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctrl_q <= '0;
    end else if (adv_a) begin
      a_ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      a_first_q <= first_i;
      a_max_q   <= max_i;
      a_rad_q   <= radius_i;
      a_prod_q  <= a_prod_d;
    end
  end

  // sign bit decides against zero; sphere mode compares against the negated radius instead
  always_comb begin
    sum = SW'(a_prod_q[0]) + SW'(a_prod_q[1]) + SW'(a_prod_q[2])
          - (SW'(plane_d) <<< NORMAL_FRAC_BITS);
    lim = -(SW'(a_rad_q) <<< NORMAL_FRAC_BITS);
    case (a_ctrl_q.mode)
      MODE_POINT:  pass = !sum[SW-1] && (sum != '0);
      MODE_SPHERE: pass = !(sum < lim);
      MODE_BOX:    pass = !sum[SW-1];
      default:     pass = 1'b0;
    endcase
    b_ctrl_d          = a_ctrl_q;
    b_ctrl_d.pass_all = a_ctrl_q.pass_all && pass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_ctrl_q <= '0;
    end else if (adv_b) begin
      b_ctrl_q <= b_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      b_first_q <= a_first_q;
      b_max_q   <= a_max_q;
      b_rad_q   <= a_rad_q;
    end
  end

  assign ctrl_o   = b_ctrl_q;
  assign first_o  = b_first_q;
  assign max_o    = b_max_q;
  assign radius_o = b_rad_q;

endmodule

`default_nettype wire

/* bench/frustum_cull_test_test.sv */
`timescale 1ns / 1ps

module frustum_cull_test_test;
  import fct_pkg::*;

  // block geometry, kept at the defaults of the block
  localparam int COORD_W     = 16;
  localparam int NORMAL_FRAC = 14;
  // one unit of a Q1.14 normal times one Q15.0 coordinate unit
  localparam longint NORM_ONE = longint'(1) << NORMAL_FRAC;
  // generous bound on the whole run, far above the slowest legal schedule
  localparam int CYCLE_LIMIT = 400000;
  // margin after the last drain for stray results
  localparam int TAIL_CYCLES = 20;

  // one primitive as it travels over the input channel
  typedef struct {
    mode_e                      mode;
    logic signed [COORD_W-1:0]  fx;
    logic signed [COORD_W-1:0]  fy;
    logic signed [COORD_W-1:0]  fz;
    logic signed [COORD_W-1:0]  bx;
    logic signed [COORD_W-1:0]  by;
    logic signed [COORD_W-1:0]  bz;
    logic [COORD_W-2:0]         radius;
  } prim_t;

  // receiver stall patterns
  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_CYCLIC
  } ready_style_e;

  // all block inputs start at known values
  logic                        clk_i           = 1'b0;
  logic                        rst_ni          = 1'b0;
  logic                        in_valid_i      = 1'b0;
  logic                        in_ready_o;
  logic [1:0]                  mode_i          = '0;
  logic signed [COORD_W-1:0]   first_x_i       = '0;
  logic signed [COORD_W-1:0]   first_y_i       = '0;
  logic signed [COORD_W-1:0]   first_z_i       = '0;
  logic signed [COORD_W-1:0]   box_max_x_i     = '0;
  logic signed [COORD_W-1:0]   box_max_y_i     = '0;
  logic signed [COORD_W-1:0]   box_max_z_i     = '0;
  logic [COORD_W-2:0]          sphere_radius_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i     = 1'b0;
  logic                        inside_res_o;
  logic                        cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i       = '0;
  logic [PLANE_W-1:0]          cfg_data_i      = '0;

  // shadow of the plane registers, plus the set about to be loaded
  logic [PLANE_W-1:0] plane_regs [PLANE_COUNT] = '{default: '0};
  logic [PLANE_W-1:0] staged_planes [PLANE_COUNT];

  // primitives waiting for the driver, and verdicts waiting for the monitor
  prim_t pending_prims [$];
  logic  inside_expected [$];

  prim_t        cur_prim;
  int           gap_left     = 0;
  int           burst_left   = 0;
  int           stall_left   = 0;
  ready_style_e stall_style  = READY_ALWAYS;
  int           mismatches   = 0;
  int           results_seen = 0;
  int           cycle_count  = 0;
  logic         want;

  always #1 clk_i = ~clk_i;

  frustum_cull_test #(
    .COORD_WIDTH      (COORD_W),
    .NORMAL_FRAC_BITS (NORMAL_FRAC)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .first_z_i       (first_z_i),
    .box_max_x_i     (box_max_x_i),
    .box_max_y_i     (box_max_y_i),
    .box_max_z_i     (box_max_z_i),
    .sphere_radius_i (sphere_radius_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .inside_res_o    (inside_res_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // exact cull verdict against the shadow planes, 64-bit sums never overflow
  function automatic logic cull_inside(prim_t p);
    longint n [AXES];
    longint lo [AXES];
    longint hi [AXES];
    longint sdist;
    longint floor_lim;
    logic   ok;
    lo[0] = p.fx;
    lo[1] = p.fy;
    lo[2] = p.fz;
    hi[0] = p.bx;
    hi[1] = p.by;
    hi[2] = p.bz;
    // sphere survives a plane unless it lies more than one radius behind it
    floor_lim = -(longint'(p.radius) * NORM_ONE);
    // unused mode never passes
    ok = (p.mode != MODE_NONE);
    for (int i = 0; i < PLANE_COUNT; i++) begin
      sdist = -(longint'($signed(plane_regs[i][DIST_SLOT*FIELD_W +: FIELD_W])) * NORM_ONE);
      for (int a = 0; a < AXES; a++) begin
        n[a] = $signed(plane_regs[i][a*FIELD_W +: FIELD_W]);
        // box takes the max bound where the normal is non-negative, bounds used as given
        sdist += n[a] * ((p.mode == MODE_BOX && n[a] >= 0) ? hi[a] : lo[a]);
      end
      case (p.mode)
        MODE_POINT:  if (sdist <= 0) ok = 1'b0;
        MODE_SPHERE: if (sdist < floor_lim) ok = 1'b0;
        MODE_BOX:    if (sdist < 0) ok = 1'b0;
        default: ;
      endcase
    end
    return ok;
  endfunction

  function automatic prim_t mk_prim(mode_e m, int fx, int fy, int fz,
                                    int bx, int by, int bz, int r);
    prim_t p;
    p.mode   = m;
    p.fx     = COORD_W'(fx);
    p.fy     = COORD_W'(fy);
    p.fz     = COORD_W'(fz);
    p.bx     = COORD_W'(bx);
    p.by     = COORD_W'(by);
    p.bz     = COORD_W'(bz);
    p.radius = (COORD_W-1)'(r);
    return p;
  endfunction

  // mostly within span of the origin, sometimes anywhere or at an extreme
  function automatic logic signed [COORD_W-1:0] rand_coord(int span);
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0)
      return COORD_W'($urandom);
    if (pick == 1)
      return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    return COORD_W'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic [COORD_W-2:0] rand_radius(int span);
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0)
      return (COORD_W-1)'($urandom);
    if (pick == 1)
      return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return (COORD_W-1)'($urandom_range(0, span / 2));
  endfunction

  function automatic prim_t rand_prim(int span);
    prim_t p;
    int    pick;
    pick = $urandom_range(0, 15);
    p.mode = (pick < 5) ? MODE_POINT : (pick < 10) ? MODE_SPHERE :
             (pick < 15) ? MODE_BOX : MODE_NONE;
    p.fx = rand_coord(span);
    p.fy = rand_coord(span);
    p.fz = rand_coord(span);
    if ($urandom_range(0, 7) == 0) begin
      // independent bounds, often swapped
      p.bx = rand_coord(span);
      p.by = rand_coord(span);
      p.bz = rand_coord(span);
    end else begin
      p.bx = p.fx + COORD_W'($urandom_range(0, span));
      p.by = p.fy + COORD_W'($urandom_range(0, span));
      p.bz = p.fz + COORD_W'($urandom_range(0, span));
    end
    p.radius = rand_radius(span);
    return p;
  endfunction

  function automatic logic [FIELD_W-1:0] extreme_field();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  // write the staged planes, optionally followed by writes to the unused indexes
  task automatic load_planes(bit junk);
    for (int i = 0; i < PLANE_COUNT; i++) begin
      @(posedge clk_i);
      cfg_we_i      <= 1'b1;
      cfg_idx_i     <= CFG_IDX_W'(i);
      cfg_data_i    <= staged_planes[i];
      plane_regs[i]  = staged_planes[i];
    end
    if (junk) begin
      for (int i = PLANE_COUNT; i < (1 << CFG_IDX_W); i++) begin
        @(posedge clk_i);
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= CFG_IDX_W'(i);
        cfg_data_i <= {$urandom, $urandom};
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // opposing plane pairs along each axis, |coord| < ext inside, tilt skews the normals
  task automatic set_frustum(int ext, int tilt, bit junk);
    int comp [AXES];
    int axis;
    int sg;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      axis = 2 - i / 2;
      sg   = (i % 2 == 0) ? 1 : -1;
      for (int a = 0; a < AXES; a++)
        comp[a] = $urandom_range(0, 2 * tilt) - tilt;
      comp[axis] = sg * (16384 - int'($urandom_range(0, tilt / 2)));
      staged_planes[i] = {FIELD_W'(-ext), FIELD_W'(comp[2]), FIELD_W'(comp[1]),
                          FIELD_W'(comp[0])};
    end
    load_planes(junk);
  endtask

  task automatic set_random_planes(bit junk);
    for (int i = 0; i < PLANE_COUNT; i++)
      staged_planes[i] = {$urandom, $urandom};
    load_planes(junk);
  endtask

  task automatic set_extreme_planes(bit junk);
    for (int i = 0; i < PLANE_COUNT; i++)
      staged_planes[i] = {extreme_field(), extreme_field(), extreme_field(), extreme_field()};
    load_planes(junk);
  endtask

  // hold off until every queued item is accepted and every verdict checked
  task automatic drain_all();
    @(negedge clk_i);
    while (pending_prims.size() != 0 || in_valid_i || inside_expected.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // driver: bursts of items with random gaps, verdict predicted at acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        inside_expected.push_back(cull_inside(cur_prim));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_prims.size() != 0) begin
          cur_prim = pending_prims.pop_front();
          mode_i          <= cur_prim.mode;
          first_x_i       <= cur_prim.fx;
          first_y_i       <= cur_prim.fy;
          first_z_i       <= cur_prim.fz;
          box_max_x_i     <= cur_prim.bx;
          box_max_y_i     <= cur_prim.by;
          box_max_z_i     <= cur_prim.bz;
          sphere_radius_i <= cur_prim.radius;
          in_valid_i      <= 1'b1;
          // end of burst picks the next gap, zero gaps give back-to-back stretches
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0:       gap_left <= 0;
              1, 2:    gap_left <= $urandom_range(1, 4);
              default: gap_left <= $urandom_range(5, 30);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stall pattern and in-order verdict check
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_style = ready_style_e'($urandom_range(0, 3));
        stall_left  = $urandom_range(16, 200);
      end else begin
        stall_left--;
      end
      case (stall_style)
        READY_ALWAYS: out_ready_i <= 1'b1;
        READY_COIN:   out_ready_i <= ($urandom_range(0, 1) != 0);
        READY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:      out_ready_i <= ((stall_left % 8) < 5);
      endcase

      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (inside_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d: inside_res %0b with nothing pending",
                     results_seen, inside_res_o);
        end else begin
          want = inside_expected.pop_front();
          if (inside_res_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: inside_res expected %0b got %0b",
                       results_seen, want, inside_res_o);
          end
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int ext;
    int span;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // planes still at reset: every distance is zero
    pending_prims.push_back(mk_prim(MODE_POINT,  0, 0, 0, 0, 0, 0, 0));
    pending_prims.push_back(mk_prim(MODE_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    pending_prims.push_back(mk_prim(MODE_BOX,    0, 0, 0, 0, 0, 0, 0));
    pending_prims.push_back(mk_prim(MODE_NONE,   0, 0, 0, 0, 0, 0, 0));
    drain_all();

    // axis-aligned frustum, inside for |coord| < 1600
    set_frustum(1600, 0, 1'b0);
    // unused box and radius fields at extremes must not matter
    pending_prims.push_back(mk_prim(MODE_POINT, 0, 0, 0, 32767, -32768, 32767, 32767));
    // point exactly on a plane fails, one step in passes
    pending_prims.push_back(mk_prim(MODE_POINT, -1600, 0, 0, 0, 0, 0, 0));
    pending_prims.push_back(mk_prim(MODE_POINT, -1599, 0, 0, 0, 0, 0, 0));
    // sphere touching from outside passes, one step further fails
    pending_prims.push_back(mk_prim(MODE_SPHERE, -1700, 0, 0, 0, 0, 0, 100));
    pending_prims.push_back(mk_prim(MODE_SPHERE, -1701, 0, 0, 0, 0, 0, 100));
    pending_prims.push_back(mk_prim(MODE_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767));
    pending_prims.push_back(mk_prim(MODE_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0));
    pending_prims.push_back(mk_prim(MODE_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    pending_prims.push_back(mk_prim(MODE_BOX, 2000, 0, 0, 2000, 0, 0, 0));
    // swapped bounds are taken as given
    pending_prims.push_back(mk_prim(MODE_BOX, 1000, 0, 0, -1000, 0, 0, 0));
    pending_prims.push_back(mk_prim(MODE_BOX, 3000, 0, 0, -3000, 0, 0, 0));
    pending_prims.push_back(mk_prim(MODE_BOX, -2000, -2000, -2000, 0, 0, 0, 0));
    pending_prims.push_back(mk_prim(MODE_NONE, 0, 0, 0, 0, 0, 0, 0));
    drain_all();

    // extreme normals and distances against extreme coordinates
    set_extreme_planes(1'b1);
    for (int m = 0; m < 4; m++) begin
      pending_prims.push_back(mk_prim(mode_e'(m), -32768, -32768, -32768,
                                      -32768, -32768, -32768, 0));
      pending_prims.push_back(mk_prim(mode_e'(m), 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767));
    end
    drain_all();

    // random phases, each starts from an idle block with a fresh plane set
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin
          ext  = $urandom_range(16, 12000);
          span = ext + ext / 2;
          set_frustum(ext, 0, ph[0]);
        end
        1: begin
          ext  = $urandom_range(16, 12000);
          span = ext + ext / 2;
          set_frustum(ext, $urandom_range(0, 6000), ph[0]);
        end
        2: begin
          span = 32767;
          set_random_planes(ph[0]);
        end
        default: begin
          span = 32767;
          set_extreme_planes(ph[0]);
        end
      endcase
      for (int k = 0; k < 100; k++)
        pending_prims.push_back(rand_prim(span));
      drain_all();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
